### hw/rtl/dllc_pkg.sv
// Shared types and constants of the linked list cursor engine.
package dllc_pkg;

  localparam int unsigned NodesDefault = 64;

  typedef enum logic [3:0] {
    CMD_NOP        = 4'd0,
    CMD_CLEAR      = 4'd1,
    CMD_INS_FIRST  = 4'd2,
    CMD_INS_LAST   = 4'd3,
    CMD_CUR_FIRST  = 4'd4,
    CMD_CUR_LAST   = 4'd5,
    CMD_DEL_FIRST  = 4'd6,
    CMD_DEL_LAST   = 4'd7,
    CMD_DEL_AFTER  = 4'd8,
    CMD_DEL_BEFORE = 4'd9,
    CMD_INS_AFTER  = 4'd10,
    CMD_INS_BEFORE = 4'd11,
    CMD_OVERWRITE  = 4'd12,
    CMD_NEXT       = 4'd13,
    CMD_PREV       = 4'd14,
    CMD_UNUSED     = 4'd15
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK1,
    ST_LINK2,
    ST_EXEC,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_RD_CUR,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic rd_ptr1;   // fetch the link words next to the cursor or an end
    logic rd_ptr2;   // fetch the dependent link words
    logic exec;      // run the list update
    logic wr_link;   // write the second pair of link words
    logic rd_head;   // fetch head data
    logic rd_tail;   // fetch tail data
    logic rd_cur;    // fetch cursor data
    logic out_load;  // register the result word
  } ctrl_t;

endpackage

### hw/rtl/dllc_ctrl.sv
// Command sequencer of the linked list cursor engine.
module dllc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_busy_i,
  output dllc_pkg::ctrl_t ctrl_o
);

  dllc_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dllc_pkg::ST_IDLE:    if (in_valid_i) state_d = dllc_pkg::ST_LINK1;
      dllc_pkg::ST_LINK1:   state_d = dllc_pkg::ST_LINK2;
      dllc_pkg::ST_LINK2:   state_d = dllc_pkg::ST_EXEC;
      dllc_pkg::ST_EXEC:    state_d = dllc_pkg::ST_RD_HEAD;
      dllc_pkg::ST_RD_HEAD: state_d = dllc_pkg::ST_RD_TAIL;
      dllc_pkg::ST_RD_TAIL: state_d = dllc_pkg::ST_RD_CUR;
      dllc_pkg::ST_RD_CUR:  state_d = dllc_pkg::ST_OUT;
      dllc_pkg::ST_OUT:     if (!out_busy_i) state_d = dllc_pkg::ST_IDLE;
      default:              state_d = dllc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dllc_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.load  = in_valid_i;
      end
      dllc_pkg::ST_LINK1:   ctrl_o.rd_ptr1 = 1'b1;
      dllc_pkg::ST_LINK2:   ctrl_o.rd_ptr2 = 1'b1;
      dllc_pkg::ST_EXEC:    ctrl_o.exec = 1'b1;
      dllc_pkg::ST_RD_HEAD: begin
        ctrl_o.rd_head = 1'b1;
        ctrl_o.wr_link = 1'b1;
      end
      dllc_pkg::ST_RD_TAIL: ctrl_o.rd_tail = 1'b1;
      dllc_pkg::ST_RD_CUR:  ctrl_o.rd_cur = 1'b1;
      dllc_pkg::ST_OUT:     ctrl_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dllc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/dllc_datapath.sv
// Node pool, list pointers and result register of the cursor engine.
module dllc_datapath #(
  parameter int unsigned Nodes = dllc_pkg::NodesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dllc_pkg::ctrl_t ctrl_i,
  input  logic [3:0]      command_i,
  input  logic [31:0]     value_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            out_busy_o,
  output logic [106:0]    result_o
);

  localparam int unsigned IW = $clog2(Nodes + 1);
  localparam int unsigned AW = (Nodes > 1) ? $clog2(Nodes) : 1;
  localparam logic [IW-1:0] Nil = IW'(Nodes);

  // link words and data words, each a memory with one registered read
  logic [IW-1:0] next_mem [Nodes];
  logic [IW-1:0] prev_mem [Nodes];
  logic [31:0]   data_mem [Nodes];

  logic [IW-1:0] head_q, tail_q, cur_q, free_q, fresh_q, cnt_q;
  logic [IW-1:0] head_d, tail_d, cur_d, free_d, fresh_d, cnt_d;
  logic [3:0]    cmd_q;
  logic [31:0]   val_q;
  logic          err_q, err_d;
  logic [31:0]   rd_q, hv_q, tv_q;
  logic [106:0]  res_q;
  logic          ovalid_q;

  // link words fetched ahead of the update
  logic [IW-1:0] rn1_q, rp1_q, rn2_q, rp2_q;
  logic [IW-1:0] nraddr, praddr;

  // link write ports: port 0 in the update cycle, port 1 in the cycle after
  logic          wn0, wn1, wp0, wp1, wdat;
  logic [IW-1:0] an0, an1, ap0, ap1, vn0, vn1, vp0, vp1, adat;
  logic          wn1_q, wp1_q;
  logic [IW-1:0] an1_q, ap1_q, vn1_q, vp1_q;
  logic          nwe, pwe;
  logic [IW-1:0] nwa, nwd, pwa, pwd;

  logic [IW-1:0] n, a, b;
  logic          ok;

  // pick the link addresses for the two fetch cycles
  always_comb begin
    nraddr = cur_q;
    praddr = cur_q;
    if (ctrl_i.rd_ptr1) begin
      if (cmd_q == dllc_pkg::CMD_DEL_FIRST) nraddr = head_q;
      if (cmd_q == dllc_pkg::CMD_DEL_LAST)  praddr = tail_q;
    end else begin
      nraddr = (cmd_q == dllc_pkg::CMD_DEL_AFTER) ? rn1_q : free_q;
      praddr = rp1_q;
    end
  end

  // list update for one command
  always_comb begin
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; free_d = free_q;
    fresh_d = fresh_q; cnt_d = cnt_q; err_d = 1'b0;
    wn0 = 1'b0; wn1 = 1'b0; wp0 = 1'b0; wp1 = 1'b0; wdat = 1'b0;
    an0 = Nil; an1 = Nil; ap0 = Nil; ap1 = Nil;
    vn0 = Nil; vn1 = Nil; vp0 = Nil; vp1 = Nil; adat = Nil;
    n = Nil; a = Nil; b = Nil; ok = 1'b0;
    // allocation candidate
    if (free_q != Nil) begin
      n = free_q; ok = 1'b1;
    end else if (fresh_q != Nil) begin
      n = fresh_q; ok = 1'b1;
    end
    unique case (dllc_pkg::cmd_e'(cmd_q))
      dllc_pkg::CMD_CLEAR: begin
        if (head_q != Nil) begin
          wn0 = 1'b1; an0 = tail_q; vn0 = free_q; free_d = head_q;
        end
        head_d = Nil; tail_d = Nil; cur_d = Nil; cnt_d = '0;
      end
      dllc_pkg::CMD_INS_FIRST, dllc_pkg::CMD_INS_LAST,
      dllc_pkg::CMD_INS_AFTER, dllc_pkg::CMD_INS_BEFORE: begin
        if ((cmd_q == dllc_pkg::CMD_INS_AFTER || cmd_q == dllc_pkg::CMD_INS_BEFORE)
            && cur_q == Nil) begin
          // inactive: nothing
        end else if (!ok) begin
          err_d = 1'b1;
        end else begin
          if (free_q != Nil) free_d = rn2_q;
          else fresh_d = fresh_q + 1'b1;
          wdat = 1'b1; adat = n; cnt_d = cnt_q + 1'b1;
          wn0 = 1'b1; an0 = n; wp0 = 1'b1; ap0 = n;
          if (cmd_q == dllc_pkg::CMD_INS_FIRST) begin
            vp0 = Nil; vn0 = head_q;
            if (head_q != Nil) begin wp1 = 1'b1; ap1 = head_q; vp1 = n; end
            else tail_d = n;
            head_d = n;
          end else if (cmd_q == dllc_pkg::CMD_INS_LAST) begin
            vn0 = Nil; vp0 = tail_q;
            if (tail_q != Nil) begin wn1 = 1'b1; an1 = tail_q; vn1 = n; end
            else head_d = n;
            tail_d = n;
          end else if (cmd_q == dllc_pkg::CMD_INS_AFTER) begin
            b = rn1_q;
            vp0 = cur_q; vn0 = b;
            if (b == Nil) tail_d = n; else begin wp1 = 1'b1; ap1 = b; vp1 = n; end
            wn1 = 1'b1; an1 = cur_q; vn1 = n;
          end else begin
            b = rp1_q;
            vn0 = cur_q; vp0 = b;
            if (b == Nil) head_d = n; else begin wn1 = 1'b1; an1 = b; vn1 = n; end
            wp1 = 1'b1; ap1 = cur_q; vp1 = n;
          end
        end
      end
      dllc_pkg::CMD_CUR_FIRST: cur_d = head_q;
      dllc_pkg::CMD_CUR_LAST:  cur_d = tail_q;
      dllc_pkg::CMD_DEL_FIRST, dllc_pkg::CMD_DEL_LAST: begin
        a = (cmd_q == dllc_pkg::CMD_DEL_FIRST) ? head_q : tail_q;
        if (a != Nil) begin
          b = (cmd_q == dllc_pkg::CMD_DEL_FIRST) ? rn1_q : rp1_q;
          if (b == Nil) begin
            head_d = Nil; tail_d = Nil; cur_d = Nil;
          end else begin
            if (cmd_q == dllc_pkg::CMD_DEL_FIRST) begin
              head_d = b; wp1 = 1'b1; ap1 = b; vp1 = Nil;
            end else begin
              tail_d = b; wn1 = 1'b1; an1 = b; vn1 = Nil;
            end
            if (cur_q == a) cur_d = Nil;
          end
          wn0 = 1'b1; an0 = a; vn0 = free_q; free_d = a;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      dllc_pkg::CMD_DEL_AFTER: begin
        if (cur_q != Nil && cur_q != tail_q) begin
          a = rn1_q;
          b = rn2_q;
          wn1 = 1'b1; an1 = cur_q; vn1 = b;
          if (b == Nil) tail_d = cur_q; else begin wp1 = 1'b1; ap1 = b; vp1 = cur_q; end
          if (a != Nil) begin
            wn0 = 1'b1; an0 = a; vn0 = free_q; free_d = a;
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          end
        end
      end
      dllc_pkg::CMD_DEL_BEFORE: begin
        if (cur_q != Nil && cur_q != head_q) begin
          a = rp1_q;
          b = rp2_q;
          wp1 = 1'b1; ap1 = cur_q; vp1 = b;
          if (b == Nil) head_d = cur_q; else begin wn1 = 1'b1; an1 = b; vn1 = cur_q; end
          if (a != Nil) begin
            wn0 = 1'b1; an0 = a; vn0 = free_q; free_d = a;
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          end
        end
      end
      dllc_pkg::CMD_OVERWRITE: if (cur_q != Nil) begin wdat = 1'b1; adat = cur_q; end
      dllc_pkg::CMD_NEXT: if (cur_q != Nil) cur_d = rn1_q;
      dllc_pkg::CMD_PREV: if (cur_q != Nil) cur_d = rp1_q;
      default: ;
    endcase
  end

  // one link write per memory and cycle: port 0 on update, port 1 after
  always_comb begin
    nwe = 1'b0; pwe = 1'b0;
    nwa = an0;  nwd = vn0;
    pwa = ap0;  pwd = vp0;
    if (ctrl_i.exec) begin
      nwe = wn0 && an0 != Nil;
      pwe = wp0 && ap0 != Nil;
    end else if (ctrl_i.wr_link) begin
      nwe = wn1_q && an1_q != Nil; nwa = an1_q; nwd = vn1_q;
      pwe = wp1_q && ap1_q != Nil; pwa = ap1_q; pwd = vp1_q;
    end
  end

  // link memories: registered reads, one write each
  always_ff @(posedge clk_i) begin
    if (nwe) next_mem[nwa[AW-1:0]] <= nwd;
    if (pwe) prev_mem[pwa[AW-1:0]] <= pwd;
    if (ctrl_i.rd_ptr1) begin
      rn1_q <= (nraddr == Nil) ? Nil : next_mem[nraddr[AW-1:0]];
      rp1_q <= (praddr == Nil) ? Nil : prev_mem[praddr[AW-1:0]];
    end
    if (ctrl_i.rd_ptr2) begin
      rn2_q <= (nraddr == Nil) ? Nil : next_mem[nraddr[AW-1:0]];
      rp2_q <= (praddr == Nil) ? Nil : prev_mem[praddr[AW-1:0]];
    end
    // hold the second write pair for the cycle after the update
    if (ctrl_i.exec) begin
      wn1_q <= wn1; an1_q <= an1; vn1_q <= vn1;
      wp1_q <= wp1; ap1_q <= ap1; vp1_q <= vp1;
    end
  end

  // data memory: one write, one registered read
  logic [IW-1:0] raddr;
  always_comb begin
    raddr = ctrl_i.rd_head ? head_q : (ctrl_i.rd_tail ? tail_q : cur_q);
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wdat) data_mem[adat[AW-1:0]] <= val_q;
    if (ctrl_i.rd_head || ctrl_i.rd_tail || ctrl_i.rd_cur) begin
      rd_q <= (raddr == Nil) ? 32'd0 : data_mem[raddr[AW-1:0]];
    end
    if (ctrl_i.rd_tail) hv_q <= rd_q;
    if (ctrl_i.rd_cur)  tv_q <= rd_q;
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      val_q <= value_i;
    end
    if (ctrl_i.out_load) begin
      res_q <= {7'(cnt_q), err_q, cur_q != Nil, rd_q, tail_q != Nil, tv_q,
                head_q != Nil, hv_q};
    end
  end

  // list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= Nil; tail_q <= Nil; cur_q <= Nil; free_q <= Nil;
      fresh_q <= '0; cnt_q <= '0; err_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d; free_q <= free_d;
        fresh_q <= fresh_d; cnt_q <= cnt_d; err_q <= err_d;
      end
      if (ctrl_i.out_load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_busy_o  = ovalid_q && !out_ready_i;
  assign result_o    = res_q;

endmodule

### hw/rtl/doubly_linked_list_cursor_engine.sv
// Top level of the doubly linked list cursor engine.
//  channel | dir | fields
//  s_axis  | in  | command, value
//  m_axis  | out | first/last/cursor values and flags, alloc_error, count
// Each command runs through load, two link word fetches, one list update,
// three reads of the single data memory port (the second link write shares
// the first of them) and result load. A new command is taken only after
// the result has been loaded.
// A stalled result holds the sequencer; reset empties the list at once.
module doubly_linked_list_cursor_engine #(
  parameter int unsigned Nodes = dllc_pkg::NodesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // command[3:0], value[35:4], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // first_value, first_valid, last_value, last_valid, cursor_value,
  // cursor_active, alloc_error, element_count[106:100], zero pad
  output logic [111:0] m_axis_tdata
);

  dllc_pkg::ctrl_t ctrl;
  logic            busy;
  logic [106:0]    res;

  dllc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (busy),
    .ctrl_o     (ctrl)
  );

  dllc_datapath #(.Nodes(Nodes)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i      (ctrl),
    .command_i   (s_axis_tdata[3:0]),
    .value_i     (s_axis_tdata[35:4]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_busy_o  (busy),
    .result_o    (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule

### tb/dllc_scoreboard.sv
// Checker for the linked list cursor engine: predicts each status word and compares.
`timescale 1ns / 100ps

module dllc_scoreboard
  import dllc_pkg::*;
#(
  parameter int unsigned Nodes = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o,
  output int           status_seen_o,
  output int           alloc_err_seen_o
);

  localparam logic [6:0] Nil = 7'(Nodes);

  typedef struct packed {
    logic [31:0] first_value;
    logic        first_valid;
    logic [31:0] last_value;
    logic        last_valid;
    logic [31:0] cursor_value;
    logic        cursor_active;
    logic        alloc_error;
    logic [6:0]  element_count;
  } status_t;

  // shadow copy of the node pool and list pointers
  logic [31:0] pool_data [Nodes];
  logic [6:0]  pool_next [Nodes];
  logic [6:0]  pool_prev [Nodes];
  logic [6:0]  head_q, tail_q, cur_q, free_q, fresh_q, count_q;
  status_t     status_queue [$];

  function automatic logic [6:0] take_node();
    logic [6:0] n;
    if (free_q != Nil) begin
      n = free_q;
      free_q = pool_next[n];
      return n;
    end
    if (fresh_q != Nil) begin
      n = fresh_q;
      fresh_q = fresh_q + 7'd1;
      return n;
    end
    return Nil;
  endfunction

  function automatic void give_node(logic [6:0] i);
    if (i == Nil) return;
    pool_next[i] = free_q;
    free_q = i;
    if (count_q != 0) count_q = count_q - 7'd1;
  endfunction

  // advance the shadow list by one command and queue the status it yields
  function automatic void apply_command(cmd_e cmd, logic [31:0] val);
    logic [6:0] n, a, b;
    logic       err;
    status_t    st;
    err = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        if (head_q != Nil) begin
          pool_next[tail_q] = free_q;
          free_q = head_q;
        end
        head_q = Nil; tail_q = Nil; cur_q = Nil; count_q = '0;
      end
      CMD_INS_FIRST: begin
        n = take_node();
        if (n == Nil) err = 1'b1;
        else begin
          pool_data[n] = val; pool_prev[n] = Nil; pool_next[n] = head_q;
          if (head_q != Nil) pool_prev[head_q] = n; else tail_q = n;
          head_q = n; count_q++;
        end
      end
      CMD_INS_LAST: begin
        n = take_node();
        if (n == Nil) err = 1'b1;
        else begin
          pool_data[n] = val; pool_next[n] = Nil; pool_prev[n] = tail_q;
          if (tail_q != Nil) pool_next[tail_q] = n; else head_q = n;
          tail_q = n; count_q++;
        end
      end
      CMD_CUR_FIRST: cur_q = head_q;
      CMD_CUR_LAST:  cur_q = tail_q;
      CMD_DEL_FIRST: begin
        if (head_q != Nil) begin
          a = head_q; b = pool_next[a];
          if (b == Nil) begin
            head_q = Nil; tail_q = Nil; cur_q = Nil;
          end else begin
            head_q = b; pool_prev[b] = Nil;
            if (cur_q == a) cur_q = Nil;
          end
          give_node(a);
        end
      end
      CMD_DEL_LAST: begin
        if (tail_q != Nil) begin
          a = tail_q; b = pool_prev[a];
          if (b == Nil) begin
            head_q = Nil; tail_q = Nil; cur_q = Nil;
          end else begin
            tail_q = b; pool_next[b] = Nil;
            if (cur_q == a) cur_q = Nil;
          end
          give_node(a);
        end
      end
      CMD_DEL_AFTER: begin
        if (cur_q != Nil && cur_q != tail_q) begin
          a = pool_next[cur_q]; b = pool_next[a];
          pool_next[cur_q] = b;
          if (b == Nil) tail_q = cur_q; else pool_prev[b] = cur_q;
          give_node(a);
        end
      end
      CMD_DEL_BEFORE: begin
        if (cur_q != Nil && cur_q != head_q) begin
          a = pool_prev[cur_q]; b = pool_prev[a];
          pool_prev[cur_q] = b;
          if (b == Nil) head_q = cur_q; else pool_next[b] = cur_q;
          give_node(a);
        end
      end
      CMD_INS_AFTER: begin
        if (cur_q != Nil) begin
          n = take_node();
          if (n == Nil) err = 1'b1;
          else begin
            b = pool_next[cur_q];
            pool_data[n] = val; pool_prev[n] = cur_q; pool_next[n] = b;
            if (b == Nil) tail_q = n; else pool_prev[b] = n;
            pool_next[cur_q] = n; count_q++;
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (cur_q != Nil) begin
          n = take_node();
          if (n == Nil) err = 1'b1;
          else begin
            b = pool_prev[cur_q];
            pool_data[n] = val; pool_next[n] = cur_q; pool_prev[n] = b;
            if (b == Nil) head_q = n; else pool_next[b] = n;
            pool_prev[cur_q] = n; count_q++;
          end
        end
      end
      CMD_OVERWRITE: if (cur_q != Nil) pool_data[cur_q] = val;
      CMD_NEXT:      if (cur_q != Nil) cur_q = pool_next[cur_q];
      CMD_PREV:      if (cur_q != Nil) cur_q = pool_prev[cur_q];
      default: ;
    endcase
    st.first_value   = (head_q != Nil) ? pool_data[head_q] : '0;
    st.first_valid   = (head_q != Nil);
    st.last_value    = (tail_q != Nil) ? pool_data[tail_q] : '0;
    st.last_valid    = (tail_q != Nil);
    st.cursor_value  = (cur_q != Nil) ? pool_data[cur_q] : '0;
    st.cursor_active = (cur_q != Nil);
    st.alloc_error   = err;
    st.element_count = count_q;
    status_queue.push_back(st);
  endfunction

  function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  // take accepted commands and compare accepted status words
  always @(posedge clk_i or negedge rst_ni) begin
    logic [111:0] word;
    status_t      exp_s;
    if (!rst_ni) begin
      head_q = Nil; tail_q = Nil; cur_q = Nil; free_q = Nil;
      fresh_q = '0; count_q = '0;
      fail_count_o = 0; status_seen_o = 0; alloc_err_seen_o = 0;
      status_queue.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_command(cmd_e'(s_axis_tdata[3:0]), s_axis_tdata[35:4]);
      if (m_axis_tvalid && m_axis_tready) begin
        word = m_axis_tdata;
        status_seen_o++;
        if (status_queue.size() == 0) begin
          $display("%0t: unexpected status word, expected none, actual %0h", $time, word);
          fail_count_o++;
        end else begin
          exp_s = status_queue.pop_front();
          if (exp_s.alloc_error) alloc_err_seen_o++;
          report_field("first_value", exp_s.first_value, word[31:0]);
          report_field("first_valid", 32'(exp_s.first_valid), 32'(word[32]));
          report_field("last_value", exp_s.last_value, word[64:33]);
          report_field("last_valid", 32'(exp_s.last_valid), 32'(word[65]));
          report_field("cursor_value", exp_s.cursor_value, word[97:66]);
          report_field("cursor_active", 32'(exp_s.cursor_active), 32'(word[98]));
          report_field("alloc_error", 32'(exp_s.alloc_error), 32'(word[99]));
          report_field("element_count", 32'(exp_s.element_count), 32'(word[106:100]));
        end
      end
    end
    pending_o = status_queue.size();
  end

endmodule

### tb/tb_doubly_linked_list_cursor_engine.sv
// Testbench top for the linked list cursor engine: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_doubly_linked_list_cursor_engine;
  import dllc_pkg::*;

  localparam int CycleLimit = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  int           fail_count, pending, status_seen, alloc_err_seen;
  int           cycles = 0;
  int           commands_sent = 0;
  int           sink_wait = 0;
  bit           quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  doubly_linked_list_cursor_engine u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dllc_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .status_seen_o(status_seen), .alloc_err_seen_o(alloc_err_seen)
  );

  // stall the status channel at random after each accepted word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= (sink_wait == 0);
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_wait = quiet ? 0 : $urandom_range(0, 17);
      m_axis_tready <= (sink_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_command(cmd_e cmd, logic [31:0] val);
    int  gap;
    bit  ready_seen;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, val, cmd};
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    commands_sent++;
  endtask

  // pick a command, leaning toward growth or shrinkage by phase
  function automatic cmd_e pick_command(int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return (r == 0) ? CMD_NOP : (r == 1) ? CMD_UNUSED : CMD_CLEAR;
    if (r < 18) return ($urandom_range(0, 1)) ? CMD_CUR_FIRST : CMD_CUR_LAST;
    if (r < 30) return ($urandom_range(0, 1)) ? CMD_NEXT : CMD_PREV;
    if (r < 35) return CMD_OVERWRITE;
    if (phase == 0) begin
      case ($urandom_range(0, 4))
        0: return CMD_INS_FIRST;
        1: return CMD_INS_LAST;
        2: return CMD_INS_AFTER;
        3: return CMD_INS_BEFORE;
        default: return CMD_DEL_AFTER;
      endcase
    end
    if (phase == 1) begin
      case ($urandom_range(0, 4))
        0: return CMD_DEL_FIRST;
        1: return CMD_DEL_LAST;
        2: return CMD_DEL_AFTER;
        3: return CMD_DEL_BEFORE;
        default: return CMD_INS_LAST;
      endcase
    end
    return cmd_e'($urandom_range(2, 11));
  endfunction

  initial begin
    int phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty and inactive cases, extremes, ends of the list
    send_command(CMD_NOP, 32'hFFFF_FFFF);
    send_command(CMD_CUR_FIRST, '0);
    send_command(CMD_CUR_LAST, '0);
    send_command(CMD_DEL_FIRST, '0);
    send_command(CMD_DEL_LAST, '0);
    send_command(CMD_INS_AFTER, 32'h1234_5678);
    send_command(CMD_DEL_BEFORE, '0);
    send_command(CMD_NEXT, '0);
    send_command(CMD_OVERWRITE, 32'h5555_5555);
    send_command(CMD_INS_FIRST, 32'h8000_0000);
    send_command(CMD_INS_LAST, 32'h7FFF_FFFF);
    send_command(CMD_CUR_FIRST, '0);
    send_command(CMD_DEL_BEFORE, '0);
    send_command(CMD_INS_AFTER, 32'h0000_0000);
    send_command(CMD_INS_BEFORE, 32'hFFFF_FFFF);
    send_command(CMD_PREV, '0);
    send_command(CMD_CUR_LAST, '0);
    send_command(CMD_DEL_AFTER, '0);
    send_command(CMD_OVERWRITE, 32'hAAAA_AAAA);
    send_command(CMD_NEXT, '0);
    send_command(CMD_CUR_FIRST, '0);
    send_command(CMD_DEL_FIRST, '0);
    send_command(CMD_UNUSED, 32'h0F0F_0F0F);
    send_command(CMD_CLEAR, '0);

    // random: growth, shrink and mixed phases, picked at random
    for (int i = 0; i < 1046; i++) begin
      if (i % 60 == 0) begin
        phase = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 4) == 0);
      end
      // drain everything once before going on
      if (i == 600) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      // fill the pool to overflow now and then
      if (i % 300 == 150) begin
        repeat (70) send_command(($urandom_range(0, 1)) ? CMD_INS_LAST : CMD_INS_FIRST,
                                 $urandom);
      end
      send_command(pick_command(phase), $urandom);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d status words, %0d with pool exhausted.",
             commands_sent, status_seen, alloc_err_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
